/* hdl/bfe_pkg.sv */
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types, constants and command/status structs of the bloom filter engine
// ----------------------------------------------------------------------------
package bfe_pkg;

  localparam int FILTER_BITS_DEF = 65536;
  localparam int MAX_HASHES_DEF  = 16;

  localparam int CFG_IW = 8;
  localparam int CFG_DW = 32;
  localparam int FBU_W  = 17;
  localparam int HC_W   = 5;

  localparam logic [CFG_IW-1:0] REG_FILTER_BITS_USED = 8'd0;
  localparam logic [CFG_IW-1:0] REG_HASH_COUNT       = 8'd1;

  localparam logic [FBU_W-1:0] FBU_RESET = 17'd47;
  localparam logic [HC_W-1:0]  HC_RESET  = 5'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] MM_F1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MM_F2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] MM_LEN = 64'd8;

  // partial product phases of a 64x64 low-half multiply
  localparam logic [1:0] MPH_LL = 2'd0;
  localparam logic [1:0] MPH_LH = 2'd1;
  localparam logic [1:0] MPH_HL = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_M1, ST_ROT, ST_M2, ST_MIX, ST_XS0, ST_MF1, ST_XS1,
    ST_MF2, ST_XS2, ST_SWAP, ST_FIN, ST_MOD, ST_INIT, ST_LOOP
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLR, DP_LOAD, DP_MUL, DP_ROT, DP_MIX, DP_XS, DP_SWAP, DP_FIN,
    DP_MOD, DP_INIT, DP_LOOP, DP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    MC_C1, MC_C2, MC_F1, MC_F2
  } mconst_t;

  typedef struct packed {
    dp_op_t     op;
    mconst_t    mc;
    logic [1:0] mph;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic loop_last;
    logic is_query;
    logic out_free;
  } dp_sts_t;

endpackage

/* hdl/bfe_in_if.sv */
// ----------------------------------------------------------------------------
// bfe_in_if
// Input channel: operation and key with valid/ready
// ----------------------------------------------------------------------------
interface bfe_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

/* hdl/bfe_out_if.sv */
// ----------------------------------------------------------------------------
// bfe_out_if
// Result channel: query answer with valid/ready
// ----------------------------------------------------------------------------
interface bfe_out_if;
  logic valid;
  logic ready;
  logic present;

  modport source (output valid, output present, input ready);
  modport sink (input valid, input present, output ready);
endinterface

/* hdl/bfe_cfg_if.sv */
// ----------------------------------------------------------------------------
// bfe_cfg_if
// Configuration write channel: register index and data with valid/ready
// ----------------------------------------------------------------------------
interface bfe_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bfe_pkg::CFG_IW-1:0] index;
  logic [bfe_pkg::CFG_DW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/bloom_filter_engine_core.sv */
// a query's result passes through hashing, reduction, index setup, one bit access per hash,
// then the read drain and the result register
// one item at a time, paced by the shared 32x32 multiplier and the one-bit-per-cycle
// remainder unit; a query's result must reach the result register before the next item is taken
// reset: a clearing pass zeroes every filter memory bit, input not ready meanwhile
// configuration writes are taken at any time, registers reset to m=47, k=3
// ----------------------------------------------------------------------------
// bloom_filter_engine_core
// Bloom filter over 64-bit keys with murmur3 x64-128 double hashing
// ----------------------------------------------------------------------------
module bloom_filter_engine_core #(
  parameter int FILTER_BITS = bfe_pkg::FILTER_BITS_DEF,
  parameter int MAX_HASHES  = bfe_pkg::MAX_HASHES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bfe_in_if.sink      in_if,
  bfe_out_if.source   out_if,
  bfe_cfg_if.sink     cfg_if
);

  bfe_pkg::dp_cmd_t cmd;
  bfe_pkg::dp_sts_t sts;
  logic             in_ready;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;

  bfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfe_dpath #(
    .FILTER_BITS (FILTER_BITS),
    .MAX_HASHES  (MAX_HASHES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_if.op),
    .in_key      (in_if.key),
    .cfg_valid   (cfg_if.valid),
    .cfg_index   (cfg_if.index),
    .cfg_data    (cfg_if.data),
    .out_valid   (out_if.valid),
    .out_present (out_if.present),
    .out_ready   (out_if.ready)
  );

endmodule

/* hdl/bfe_ctrl.sv */
// ----------------------------------------------------------------------------
// bfe_ctrl
// Sequencer: clearing pass, result hand-off, hash micro-steps, reduction and index loop
// ----------------------------------------------------------------------------
module bfe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bfe_pkg::dp_sts_t  sts,
  output bfe_pkg::dp_cmd_t  cmd
);

  bfe_pkg::state_t state_r, state_nxt;
  logic [1:0]      mph_r, mph_nxt;
  logic            pass_r, pass_nxt;
  logic            emit_r, emit_nxt;
  logic            drain_r, drain_nxt;

  logic mul_state;
  assign mul_state = (state_r == bfe_pkg::ST_M1) || (state_r == bfe_pkg::ST_M2) ||
                     (state_r == bfe_pkg::ST_MF1) || (state_r == bfe_pkg::ST_MF2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfe_pkg::ST_CLEAR;
      mph_r   <= bfe_pkg::MPH_LL;
      pass_r  <= 1'b0;
      emit_r  <= 1'b0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mph_r   <= mph_nxt;
      pass_r  <= pass_nxt;
      emit_r  <= emit_nxt;
      drain_r <= drain_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    mph_nxt   = bfe_pkg::MPH_LL;
    pass_nxt  = pass_r;
    emit_nxt  = emit_r;
    drain_nxt = drain_r;
    if (mul_state && mph_r != bfe_pkg::MPH_HL) begin
      mph_nxt = mph_r + 2'd1;
    end
    unique case (state_r)
      bfe_pkg::ST_CLEAR: if (sts.clr_last) state_nxt = bfe_pkg::ST_IDLE;
      bfe_pkg::ST_IDLE: begin
        priority if (drain_r) begin
          drain_nxt = 1'b0;
          emit_nxt  = 1'b1;
        end else if (emit_r) begin
          if (sts.out_free) emit_nxt = 1'b0;
        end else if (in_valid) begin
          state_nxt = bfe_pkg::ST_M1;
          pass_nxt  = 1'b0;
        end
      end
      bfe_pkg::ST_M1:   if (mph_r == bfe_pkg::MPH_HL) state_nxt = bfe_pkg::ST_ROT;
      bfe_pkg::ST_ROT:  state_nxt = bfe_pkg::ST_M2;
      bfe_pkg::ST_M2:   if (mph_r == bfe_pkg::MPH_HL) state_nxt = bfe_pkg::ST_MIX;
      bfe_pkg::ST_MIX:  state_nxt = bfe_pkg::ST_XS0;
      bfe_pkg::ST_XS0:  state_nxt = bfe_pkg::ST_MF1;
      bfe_pkg::ST_MF1:  if (mph_r == bfe_pkg::MPH_HL) state_nxt = bfe_pkg::ST_XS1;
      bfe_pkg::ST_XS1:  state_nxt = bfe_pkg::ST_MF2;
      bfe_pkg::ST_MF2:  if (mph_r == bfe_pkg::MPH_HL) state_nxt = bfe_pkg::ST_XS2;
      bfe_pkg::ST_XS2:  state_nxt = pass_r ? bfe_pkg::ST_FIN : bfe_pkg::ST_SWAP;
      bfe_pkg::ST_SWAP: begin
        state_nxt = bfe_pkg::ST_XS0;
        pass_nxt  = 1'b1;
      end
      bfe_pkg::ST_FIN:  state_nxt = bfe_pkg::ST_MOD;
      bfe_pkg::ST_MOD:  if (sts.mod_last) state_nxt = bfe_pkg::ST_INIT;
      bfe_pkg::ST_INIT: state_nxt = bfe_pkg::ST_LOOP;
      bfe_pkg::ST_LOOP: begin
        if (sts.loop_last) begin
          state_nxt = bfe_pkg::ST_IDLE;
          drain_nxt = sts.is_query;
        end
      end
      default: state_nxt = bfe_pkg::ST_CLEAR;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op   = bfe_pkg::DP_NOP;
    cmd.mc   = bfe_pkg::MC_C1;
    cmd.mph  = mph_r;
    in_ready = 1'b0;
    unique case (state_r)
      bfe_pkg::ST_CLEAR: cmd.op = bfe_pkg::DP_CLR;
      bfe_pkg::ST_IDLE: begin
        priority if (drain_r) begin
          cmd.op = bfe_pkg::DP_NOP;
        end else if (emit_r) begin
          if (sts.out_free) cmd.op = bfe_pkg::DP_EMIT;
        end else begin
          in_ready = 1'b1;
          if (in_valid) cmd.op = bfe_pkg::DP_LOAD;
        end
      end
      bfe_pkg::ST_M1: begin
        cmd.op = bfe_pkg::DP_MUL;
        cmd.mc = bfe_pkg::MC_C1;
      end
      bfe_pkg::ST_M2: begin
        cmd.op = bfe_pkg::DP_MUL;
        cmd.mc = bfe_pkg::MC_C2;
      end
      bfe_pkg::ST_MF1: begin
        cmd.op = bfe_pkg::DP_MUL;
        cmd.mc = bfe_pkg::MC_F1;
      end
      bfe_pkg::ST_MF2: begin
        cmd.op = bfe_pkg::DP_MUL;
        cmd.mc = bfe_pkg::MC_F2;
      end
      bfe_pkg::ST_ROT:  cmd.op = bfe_pkg::DP_ROT;
      bfe_pkg::ST_MIX:  cmd.op = bfe_pkg::DP_MIX;
      bfe_pkg::ST_XS0,
      bfe_pkg::ST_XS1,
      bfe_pkg::ST_XS2:  cmd.op = bfe_pkg::DP_XS;
      bfe_pkg::ST_SWAP: cmd.op = bfe_pkg::DP_SWAP;
      bfe_pkg::ST_FIN:  cmd.op = bfe_pkg::DP_FIN;
      bfe_pkg::ST_MOD:  cmd.op = bfe_pkg::DP_MOD;
      bfe_pkg::ST_INIT: cmd.op = bfe_pkg::DP_INIT;
      bfe_pkg::ST_LOOP: cmd.op = bfe_pkg::DP_LOOP;
      default:          cmd.op = bfe_pkg::DP_NOP;
    endcase
  end

endmodule

/* hdl/bfe_dpath.sv */
// ----------------------------------------------------------------------------
// bfe_dpath
// Hash registers, shared 32x32 multiplier, remainder unit, index generator,
// filter bit memory, configuration registers and result register
// ----------------------------------------------------------------------------
module bfe_dpath #(
  parameter int FILTER_BITS = bfe_pkg::FILTER_BITS_DEF,
  parameter int MAX_HASHES  = bfe_pkg::MAX_HASHES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bfe_pkg::dp_cmd_t           cmd,
  output bfe_pkg::dp_sts_t           sts,
  input  logic                       in_op,
  input  logic [63:0]                in_key,
  input  logic                       cfg_valid,
  input  logic [bfe_pkg::CFG_IW-1:0] cfg_index,
  input  logic [bfe_pkg::CFG_DW-1:0] cfg_data,
  output logic                       out_valid,
  output logic                       out_present,
  input  logic                       out_ready
);

  localparam int MW = $clog2(FILTER_BITS + 1);
  localparam int AW = (FILTER_BITS > 1) ? $clog2(FILTER_BITS) : 1;
  localparam int KW = $clog2(MAX_HASHES + 1);

  // configuration
  logic [bfe_pkg::FBU_W-1:0] fbu_r;
  logic [bfe_pkg::HC_W-1:0]  hc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbu_r <= bfe_pkg::FBU_RESET;
      hc_r  <= bfe_pkg::HC_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == bfe_pkg::REG_FILTER_BITS_USED) fbu_r <= cfg_data[bfe_pkg::FBU_W-1:0];
      if (cfg_index == bfe_pkg::REG_HASH_COUNT)       hc_r  <= cfg_data[bfe_pkg::HC_W-1:0];
    end
  end

  logic [MW-1:0] m_eff;
  logic [KW-1:0] k_eff;

  always_comb begin
    priority if (fbu_r == '0) m_eff = MW'(1);
    else if (32'(fbu_r) > 32'(FILTER_BITS)) m_eff = MW'(FILTER_BITS);
    else m_eff = MW'(fbu_r);
    priority if (hc_r == '0) k_eff = KW'(1);
    else if (32'(hc_r) > 32'(MAX_HASHES)) k_eff = KW'(MAX_HASHES);
    else k_eff = KW'(hc_r);
  end

  // hash state
  logic [63:0]   a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic          op_r;
  logic [MW-1:0] m_r;
  logic [KW-1:0] k_r;

  logic [63:0] mc;
  logic [31:0] mul_x, mul_y;
  logic [63:0] prod;

  always_comb begin
    unique case (cmd.mc)
      bfe_pkg::MC_C1: mc = bfe_pkg::MM_C1;
      bfe_pkg::MC_C2: mc = bfe_pkg::MM_C2;
      bfe_pkg::MC_F1: mc = bfe_pkg::MM_F1;
      bfe_pkg::MC_F2: mc = bfe_pkg::MM_F2;
      default:        mc = bfe_pkg::MM_C1;
    endcase
    unique case (cmd.mph)
      bfe_pkg::MPH_LH: begin
        mul_x = a_r[31:0];
        mul_y = mc[63:32];
      end
      bfe_pkg::MPH_HL: begin
        mul_x = a_r[63:32];
        mul_y = mc[31:0];
      end
      default: begin
        mul_x = a_r[31:0];
        mul_y = mc[31:0];
      end
    endcase
  end

  assign prod = 64'(mul_x) * 64'(mul_y);

  // remainder unit, one bit of lo and hi per cycle
  logic [MW-1:0] r1_r, r1_nxt, r2_r, r2_nxt;
  logic [5:0]    mcnt_r;
  logic [MW:0]   s1, s2;

  assign s1 = {r1_r, a_r[63]};
  assign s2 = {r2_r, b_r[63]};

  // index generator
  logic [KW-1:0] i_r;
  logic [MW-1:0] v_r, v_nxt, lin_r, lin_nxt, idx;
  logic [MW+1:0] vs0, vs1, ls0, ls1;

  always_comb begin
    vs0 = (MW+2)'(v_r) + (MW+2)'(r2_r) + (MW+2)'(lin_r);
    vs1 = (vs0 >= (MW+2)'(m_r)) ? vs0 - (MW+2)'(m_r) : vs0;
    v_nxt = (vs1 >= (MW+2)'(m_r)) ? MW'(vs1 - (MW+2)'(m_r)) : MW'(vs1);
    ls0 = (MW+2)'(lin_r) + (MW+2)'(2);
    ls1 = (ls0 >= (MW+2)'(m_r)) ? ls0 - (MW+2)'(m_r) : ls0;
    lin_nxt = (ls1 >= (MW+2)'(m_r)) ? MW'(ls1 - (MW+2)'(m_r)) : MW'(ls1);
    priority if (i_r == KW'(0)) idx = r1_r;
    else if (i_r == KW'(1)) idx = r2_r;
    else idx = v_r;
  end

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    acc_nxt = acc_r;
    r1_nxt  = r1_r;
    r2_nxt  = r2_r;
    unique case (cmd.op)
      bfe_pkg::DP_LOAD: begin
        a_nxt = in_key;
        b_nxt = '0;
      end
      bfe_pkg::DP_MUL: begin
        unique case (cmd.mph)
          bfe_pkg::MPH_LL: acc_nxt = prod;
          bfe_pkg::MPH_LH: acc_nxt = acc_r + {prod[31:0], 32'd0};
          default:         a_nxt   = acc_r + {prod[31:0], 32'd0};
        endcase
      end
      bfe_pkg::DP_ROT:  a_nxt = {a_r[32:0], a_r[63:33]};
      bfe_pkg::DP_MIX: begin
        a_nxt = (a_r ^ bfe_pkg::MM_LEN) + bfe_pkg::MM_LEN;
        b_nxt = ((a_r ^ bfe_pkg::MM_LEN) + bfe_pkg::MM_LEN) + bfe_pkg::MM_LEN;
      end
      bfe_pkg::DP_XS:   a_nxt = a_r ^ {33'd0, a_r[63:33]};
      bfe_pkg::DP_SWAP: begin
        a_nxt = b_r;
        b_nxt = a_r;
      end
      bfe_pkg::DP_FIN: begin
        a_nxt  = a_r + b_r;
        b_nxt  = a_r + (a_r + b_r);
        r1_nxt = '0;
        r2_nxt = '0;
      end
      bfe_pkg::DP_MOD: begin
        a_nxt  = {a_r[62:0], 1'b0};
        b_nxt  = {b_r[62:0], 1'b0};
        r1_nxt = (s1 >= (MW+1)'(m_r)) ? MW'(s1 - (MW+1)'(m_r)) : MW'(s1);
        r2_nxt = (s2 >= (MW+1)'(m_r)) ? MW'(s2 - (MW+1)'(m_r)) : MW'(s2);
      end
      default: ;
    endcase
  end

  // filter memory and result
  logic          mem [FILTER_BITS];
  logic          rdata_r;
  logic          rd_pend_r;
  logic          all_r;
  logic [AW-1:0] ca_r;
  logic          out_valid_r;
  logic          present_r;
  logic          we;
  logic [AW-1:0] maddr;
  logic          wd;

  always_comb begin
    we    = 1'b0;
    wd    = 1'b0;
    maddr = AW'(idx);
    if (cmd.op == bfe_pkg::DP_CLR) begin
      we    = 1'b1;
      maddr = ca_r;
    end else if (cmd.op == bfe_pkg::DP_LOOP && op_r == bfe_pkg::OP_INSERT) begin
      we = 1'b1;
      wd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[maddr] <= wd;
    rdata_r <= mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r        <= '0;
      mcnt_r      <= '0;
      i_r         <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      all_r       <= 1'b1;
    end else begin
      if (cmd.op == bfe_pkg::DP_CLR) ca_r <= ca_r + AW'(1);
      mcnt_r <= (cmd.op == bfe_pkg::DP_MOD) ? mcnt_r + 6'd1 : 6'd0;
      if (cmd.op == bfe_pkg::DP_INIT) i_r <= '0;
      else if (cmd.op == bfe_pkg::DP_LOOP) i_r <= i_r + KW'(1);
      rd_pend_r <= (cmd.op == bfe_pkg::DP_LOOP) && (op_r == bfe_pkg::OP_QUERY);
      if (cmd.op == bfe_pkg::DP_INIT) all_r <= 1'b1;
      else if (rd_pend_r) all_r <= all_r & rdata_r;
      if (cmd.op == bfe_pkg::DP_EMIT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    r1_r  <= r1_nxt;
    r2_r  <= r2_nxt;
    if (cmd.op == bfe_pkg::DP_LOAD) begin
      op_r <= in_op;
      m_r  <= m_eff;
      k_r  <= k_eff;
    end
    if (cmd.op == bfe_pkg::DP_INIT) begin
      v_r   <= r1_r;
      lin_r <= (m_r == MW'(1)) ? MW'(0) : MW'(1);
    end else if (cmd.op == bfe_pkg::DP_LOOP) begin
      v_r   <= v_nxt;
      lin_r <= lin_nxt;
    end
    if (cmd.op == bfe_pkg::DP_EMIT) present_r <= all_r;
  end

  assign sts.clr_last  = (ca_r == AW'(FILTER_BITS - 1));
  assign sts.mod_last  = (mcnt_r == 6'd63);
  assign sts.loop_last = (i_r == k_r - KW'(1));
  assign sts.is_query  = (op_r == bfe_pkg::OP_QUERY);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_present = present_r;

endmodule

/* tb/sv/tb_bloom_filter_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_engine_core
// Drives insert and query transfers through the bloom filter engine, predicts
// each query answer with a murmur3 based filter model kept in the bench, and
// compares the answers in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_bloom_filter_engine_core;

  localparam int NFB = bfe_pkg::FILTER_BITS_DEF;
  localparam int NRAND = 1825;

  typedef struct {
    logic        op;
    logic [63:0] key;
    logic        chk;   // typed-in answer present
    logic        ans;
  } stim_row_t;

  logic clk;
  logic rst_n;

  bfe_in_if  in_ch ();
  bfe_out_if out_ch ();
  bfe_cfg_if cfg_ch ();

  bloom_filter_engine_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source),
    .cfg_if (cfg_ch.sink)
  );

  // filter model
  logic                      filt_bits [NFB];
  logic [bfe_pkg::FBU_W-1:0] m_reg;
  logic [bfe_pkg::HC_W-1:0]  k_reg;
  logic                      present_q [$];
  int                        n_err;
  bit                        hold_long;
  logic [63:0]               recent_keys [$];

  function automatic logic [63:0] rotl(logic [63:0] x, int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] fmix(logic [63:0] v);
    v = v ^ (v >> 33);
    v = v * bfe_pkg::MM_F1;
    v = v ^ (v >> 33);
    v = v * bfe_pkg::MM_F2;
    v = v ^ (v >> 33);
    return v;
  endfunction

  // applies one item to the model, returns the answer a query would give
  function automatic logic filter_apply(logic op, logic [63:0] key);
    logic [63:0] t, a, b, m, k, h1, h2, idx;
    logic        all_set;
    all_set = 1'b1;
    t = rotl(key * bfe_pkg::MM_C1, 31) * bfe_pkg::MM_C2;
    a = t ^ bfe_pkg::MM_LEN;
    b = bfe_pkg::MM_LEN;
    a = a + b;
    b = b + a;
    a = fmix(a);
    b = fmix(b);
    a = a + b;
    b = b + a;
    m = (m_reg == 0) ? 64'd1 : ((m_reg > NFB) ? 64'(NFB) : 64'(m_reg));
    k = (k_reg == 0) ? 64'd1 :
        ((k_reg > bfe_pkg::MAX_HASHES_DEF) ? 64'(bfe_pkg::MAX_HASHES_DEF) : 64'(k_reg));
    h1 = a % m;
    h2 = b % m;
    for (int i = 0; i < k; i++) begin
      if (i == 0) idx = h1;
      else if (i == 1) idx = h2;
      else idx = (h1 + 64'(i) * h2 + 64'(i * i)) % m;
      if (op == bfe_pkg::OP_INSERT) filt_bits[idx] = 1'b1;
      else if (!filt_bits[idx]) all_set = 1'b0;
    end
    return all_set;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic cfg_write(logic [bfe_pkg::CFG_IW-1:0] idx, logic [bfe_pkg::CFG_DW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == bfe_pkg::REG_FILTER_BITS_USED) m_reg = val[bfe_pkg::FBU_W-1:0];
    else if (idx == bfe_pkg::REG_HASH_COUNT) k_reg = val[bfe_pkg::HC_W-1:0];
  endtask

  // drains outstanding answers and lets the last insert finish
  task automatic settle();
    while (present_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_item(logic op, logic [63:0] key, logic chk, logic ans);
    logic pred;
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.key   <= key;
    do @(posedge clk); while (!in_ch.ready);
    pred = filter_apply(op, key);
    if (op == bfe_pkg::OP_QUERY) begin
      if (chk && pred !== ans) begin
        $display("%0t: typed answer mismatch key %h expected %0b actual %0b",
                 $time, key, ans, pred);
        n_err++;
      end
      present_q.insert(present_q.size(), pred);
    end
    if (op == bfe_pkg::OP_INSERT) begin
      recent_keys.insert(recent_keys.size(), key);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
  endtask

  task automatic send_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic run_random(int n);
    logic        op;
    logic [63:0] key;
    for (int i = 0; i < n; i++) begin
      op = 1'($urandom_range(0, 1));
      key = {$urandom, $urandom};
      // queries often reuse inserted keys so hits show up
      if (op == bfe_pkg::OP_QUERY && recent_keys.size() != 0 && $urandom_range(0, 1))
        key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      send_item(op, key, 1'b0, 1'b0);
      send_gap();
    end
    in_ch.valid <= 1'b0;
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int s;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_long = 1'b0;
      end
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 50) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) s = 0;
      if (s != 0) begin
        out_ch.ready <= 1'b0;
        repeat (s - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (present_q.size() == 0) begin
        $display("%0t: unexpected answer, expected none actual %0b", $time,
                 out_ch.present);
        n_err++;
      end else if (out_ch.present !== present_q[0]) begin
        $display("%0t: present mismatch expected %0b actual %0b", $time,
                 present_q[0], out_ch.present);
        n_err++;
        void'(present_q.pop_front());
      end else begin
        void'(present_q.pop_front());
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    int        wait_cnt;
    n_err = 0;
    hold_long = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= bfe_pkg::OP_INSERT;
    in_ch.key <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= bfe_pkg::REG_FILTER_BITS_USED;
    cfg_ch.data <= '0;
    foreach (filt_bits[i]) filt_bits[i] = 1'b0;
    m_reg = bfe_pkg::FBU_RESET;
    k_reg = bfe_pkg::HC_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty filter misses, key extremes, insert then hit, under the reset register setting
    rows.insert(rows.size(), '{bfe_pkg::OP_QUERY,  64'h0, 1'b1, 1'b0});
    rows.insert(rows.size(), '{bfe_pkg::OP_QUERY,  '1,    1'b1, 1'b0});
    rows.insert(rows.size(), '{bfe_pkg::OP_INSERT, 64'h0, 1'b0, 1'b0});
    rows.insert(rows.size(), '{bfe_pkg::OP_QUERY,  64'h0, 1'b1, 1'b1});
    rows.insert(rows.size(), '{bfe_pkg::OP_INSERT, '1,    1'b0, 1'b0});
    rows.insert(rows.size(), '{bfe_pkg::OP_QUERY,  '1,    1'b1, 1'b1});
    rows.insert(rows.size(), '{bfe_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 1'b0, 1'b0});
    rows.insert(rows.size(), '{bfe_pkg::OP_QUERY,  64'h5555_5555_5555_5555, 1'b0, 1'b0});
    rows.insert(rows.size(), '{bfe_pkg::OP_QUERY,  64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0});
    foreach (rows[i]) begin
      send_item(rows[i].op, rows[i].key, rows[i].chk, rows[i].ans);
      send_gap();
    end
    in_ch.valid <= 1'b0;
    settle();

    // modulus zero: one bit, so any insert makes every query hit
    cfg_write(bfe_pkg::REG_FILTER_BITS_USED, 32'd0);
    cfg_write(bfe_pkg::REG_HASH_COUNT, 32'd0);
    send_item(bfe_pkg::OP_INSERT, 64'h1234, 1'b0, 1'b0);
    send_item(bfe_pkg::OP_QUERY, 64'hdead_beef, 1'b1, 1'b1);
    in_ch.valid <= 1'b0;
    settle();

    // oversized settings saturate; earlier bits stay set
    cfg_write(bfe_pkg::REG_FILTER_BITS_USED, 32'h1_ffff);
    cfg_write(bfe_pkg::REG_HASH_COUNT, 32'h1f);
    send_item(bfe_pkg::OP_QUERY, 64'h0, 1'b0, 1'b0);
    send_item(bfe_pkg::OP_INSERT, 64'h42, 1'b0, 1'b0);
    send_item(bfe_pkg::OP_QUERY, 64'h42, 1'b1, 1'b1);
    in_ch.valid <= 1'b0;
    settle();

    // random phases over several settings, long hold-off in the first
    cfg_write(bfe_pkg::REG_FILTER_BITS_USED, 32'd300);
    cfg_write(bfe_pkg::REG_HASH_COUNT, 32'd4);
    hold_long = 1'b1;
    run_random(NRAND / 5);
    settle();
    cfg_write(bfe_pkg::REG_FILTER_BITS_USED, 32'd65536);
    cfg_write(bfe_pkg::REG_HASH_COUNT, 32'd16);
    run_random(NRAND / 5);
    settle();
    cfg_write(bfe_pkg::REG_FILTER_BITS_USED, 32'd1);
    cfg_write(bfe_pkg::REG_HASH_COUNT, 32'd1);
    run_random(NRAND / 10);
    settle();
    cfg_write(bfe_pkg::REG_FILTER_BITS_USED, 32'd2000);
    cfg_write(bfe_pkg::REG_HASH_COUNT, 32'd2);
    run_random(NRAND / 4);
    settle();
    cfg_write(bfe_pkg::REG_FILTER_BITS_USED, 32'h0_0000 | $urandom_range(1, 65536));
    cfg_write(bfe_pkg::REG_HASH_COUNT, 32'd17 + $urandom_range(0, 14));
    run_random(NRAND / 4);

    wait_cnt = 0;
    while (present_q.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (present_q.size() != 0) begin
      $display("%0t: %0d answers never arrived", $time, present_q.size());
      n_err++;
    end
    repeat (200) @(posedge clk);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/bfe_pkg.sv
hdl/bfe_in_if.sv
hdl/bfe_out_if.sv
hdl/bfe_cfg_if.sv
hdl/bfe_ctrl.sv
hdl/bfe_dpath.sv
hdl/bloom_filter_engine_core.sv
tb/sv/tb_bloom_filter_engine_core.sv
